### rtl/core/lrpc_pkg.sv
// Shared types and constants for the log record parser.
// No dependencies.
`default_nettype none
package lrpc_pkg;
    localparam logic [1:0] KIND_KEY    = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_CLEAN   = 3'd1;
    localparam logic [2:0] ST_TRUNC   = 3'd2;
    localparam logic [2:0] ST_READERR = 3'd3;
    localparam logic [2:0] ST_BADOP   = 3'd4;
    localparam logic [2:0] ST_CRC     = 3'd5;

    localparam logic [1:0] REG_MAX_KEY = 2'd0;
    localparam logic [1:0] REG_MAX_VAL = 2'd1;
    localparam logic [1:0] REG_PUT     = 2'd2;
    localparam logic [1:0] REG_DEL     = 2'd3;

    // one result, as it travels through the queue
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic [63:0] sequence_number;
        logic        is_delete;
        logic [15:0] key_len;
        logic [23:0] value_len;
        logic        end_of_run;
    } result_t;

    // CRC-32 IEEE reflected, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            x = (x >> 1) ^ (32'hEDB88320 & {32{x[0]}});
        end
        return x;
    endfunction
endpackage
`default_nettype wire

### rtl/core/lrpc_front.sv
// Front end: accepts stream items, runs the record parser and CRC.
// Emits up to two results per item into the queue. Uses lrpc_pkg.
`default_nettype none
module lrpc_front
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  req_type,
    input  wire logic [7:0]            data_byte,
    input  wire logic [15:0]           max_key_len,
    input  wire logic [23:0]           max_value_len,
    input  wire logic [7:0]            put_code,
    input  wire logic [7:0]            delete_code,
    input  wire logic                  q_room2,
    output logic [1:0]                 push_cnt,
    output lrpc_pkg::result_t          push_a,
    output lrpc_pkg::result_t          push_b
);
    typedef enum logic [2:0] {PH_CSUM, PH_SEQ, PH_OP, PH_KLEN, PH_VLEN, PH_KEY, PH_VAL}
        phase_t;

    phase_t      phase_reg, phase_next;
    logic [23:0] cnt_reg, cnt_next;
    logic [31:0] scrc_reg, scrc_next, rcrc_reg, rcrc_next;
    logic [63:0] seq_reg, seq_next;
    logic        del_reg, del_next, halt_reg, halt_next;
    logic [31:0] ksz_reg, ksz_next, vsz_reg, vsz_next;

    logic        fire;
    logic [31:0] crc_new;
    logic        emit_b, emit_s, restart;
    logic [2:0]  st;
    logic [1:0]  bkind;
    logic        crc_ok;
    lrpc_pkg::result_t bres, sres;

    assign in_ready = q_room2;
    assign fire     = in_valid && in_ready;
    assign crc_new  = lrpc_pkg::crc_byte(rcrc_reg, data_byte);
    assign crc_ok   = ~crc_new == scrc_reg;

    always_comb
    begin
        phase_next = phase_reg; cnt_next = cnt_reg; scrc_next = scrc_reg;
        rcrc_next = rcrc_reg; seq_next = seq_reg; del_next = del_reg;
        halt_next = halt_reg; ksz_next = ksz_reg; vsz_next = vsz_reg;
        emit_b = 1'b0; emit_s = 1'b0; restart = 1'b0; st = lrpc_pkg::ST_OK;
        bkind = lrpc_pkg::KIND_KEY;
        if (fire) begin
            if (req_type) begin
                if (!halt_reg) begin
                    emit_s = 1'b1;
                    if (phase_reg == PH_CSUM && cnt_reg == 24'd0) st = lrpc_pkg::ST_CLEAN;
                    else if (phase_reg == PH_KLEN || phase_reg == PH_VLEN)
                        st = lrpc_pkg::ST_READERR;
                    else st = lrpc_pkg::ST_TRUNC;
                end
                restart = 1'b1;
            end else if (!halt_reg) begin
                if (phase_reg != PH_CSUM) rcrc_next = crc_new;
                case (phase_reg)
                    PH_CSUM:
                    begin
                        scrc_next[8*cnt_reg[1:0] +: 8] = data_byte;
                        cnt_next = cnt_reg + 24'd1;
                        if (cnt_reg[1:0] == 2'd3) begin phase_next = PH_SEQ; cnt_next = '0; end
                    end
                    PH_SEQ:
                    begin
                        seq_next[8*cnt_reg[2:0] +: 8] = data_byte;
                        cnt_next = cnt_reg + 24'd1;
                        if (cnt_reg[2:0] == 3'd7) begin phase_next = PH_OP; cnt_next = '0; end
                    end
                    PH_OP:
                    begin
                        cnt_next = '0;
                        if (data_byte == put_code) begin del_next = 1'b0; phase_next = PH_KLEN; end
                        else if (data_byte == delete_code) begin
                            del_next = 1'b1; phase_next = PH_KLEN;
                        end else begin
                            emit_s = 1'b1; st = lrpc_pkg::ST_BADOP; halt_next = 1'b1;
                        end
                    end
                    PH_KLEN:
                    begin
                        ksz_next[8*cnt_reg[1:0] +: 8] = data_byte;
                        cnt_next = cnt_reg + 24'd1;
                        if (cnt_reg[1:0] == 2'd3) begin
                            cnt_next = '0;
                            if (!del_reg) phase_next = PH_VLEN;
                            else if (ksz_next > {16'd0, max_key_len}) begin
                                emit_s = 1'b1; st = lrpc_pkg::ST_READERR; halt_next = 1'b1;
                            end else if (ksz_next == 32'd0) begin
                                emit_s = 1'b1;
                                if (crc_ok) restart = 1'b1;
                                else begin st = lrpc_pkg::ST_CRC; halt_next = 1'b1; end
                            end else phase_next = PH_KEY;
                        end
                    end
                    PH_VLEN:
                    begin
                        vsz_next[8*cnt_reg[1:0] +: 8] = data_byte;
                        cnt_next = cnt_reg + 24'd1;
                        if (cnt_reg[1:0] == 2'd3) begin
                            cnt_next = '0;
                            if (ksz_reg > {16'd0, max_key_len} ||
                                vsz_next > {8'd0, max_value_len}) begin
                                emit_s = 1'b1; st = lrpc_pkg::ST_READERR; halt_next = 1'b1;
                            end else if (ksz_reg != 32'd0) phase_next = PH_KEY;
                            else if (vsz_next != 32'd0) phase_next = PH_VAL;
                            else begin
                                emit_s = 1'b1;
                                if (crc_ok) restart = 1'b1;
                                else begin st = lrpc_pkg::ST_CRC; halt_next = 1'b1; end
                            end
                        end
                    end
                    PH_KEY, PH_VAL:
                    begin
                        emit_b = 1'b1;
                        bkind = (phase_reg == PH_KEY) ? lrpc_pkg::KIND_KEY
                                                      : lrpc_pkg::KIND_VALUE;
                        cnt_next = cnt_reg + 24'd1;
                        if ({8'd0, cnt_next} >= ((phase_reg == PH_KEY) ? ksz_reg : vsz_reg))
                        begin
                            cnt_next = '0;
                            if (phase_reg == PH_KEY && !del_reg && vsz_reg != 32'd0)
                                phase_next = PH_VAL;
                            else begin
                                emit_s = 1'b1;
                                if (crc_ok) restart = 1'b1;
                                else begin st = lrpc_pkg::ST_CRC; halt_next = 1'b1; end
                            end
                        end
                    end
                    default: restart = 1'b1;
                endcase
            end
        end
        if (restart) begin
            phase_next = PH_CSUM; cnt_next = '0; scrc_next = '0; rcrc_next = '1;
            seq_next = '0; del_next = 1'b0; halt_next = 1'b0; ksz_next = '0; vsz_next = '0;
        end
    end

    // a length that completes a record in its own field is zero, so the
    // stored lengths are already final whenever a status goes out
    always_comb
    begin
        bres = '0;
        bres.kind = bkind;
        bres.payload_byte = data_byte;
        bres.end_of_run = !emit_s;
        sres = '0;
        sres.kind = lrpc_pkg::KIND_STATUS;
        sres.status = st;
        sres.end_of_run = 1'b1;
        if (st == lrpc_pkg::ST_OK) begin
            sres.sequence_number = seq_reg;
            sres.is_delete = del_reg;
            sres.key_len = ksz_reg[15:0];
            sres.value_len = del_reg ? 24'd0 : vsz_reg[23:0];
        end
        push_cnt = {1'b0, emit_b} + {1'b0, emit_s};
        push_a = emit_b ? bres : sres;
        push_b = sres;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_CSUM; cnt_reg <= '0; scrc_reg <= '0; rcrc_reg <= '1;
            seq_reg <= '0; del_reg <= 1'b0; halt_reg <= 1'b0; ksz_reg <= '0; vsz_reg <= '0;
        end else begin
            phase_reg <= phase_next; cnt_reg <= cnt_next; scrc_reg <= scrc_next;
            rcrc_reg <= rcrc_next; seq_reg <= seq_next; del_reg <= del_next;
            halt_reg <= halt_next; ksz_reg <= ksz_next; vsz_reg <= vsz_next;
        end
    end

    a_push_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt != 2'd0 |-> fire) else $error("push without item");
    a_two_ends_status: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt == 2'd2 |-> push_b.kind == lrpc_pkg::KIND_STATUS && !push_a.end_of_run)
        else $error("bad pair");
    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg && !req_type |-> push_cnt == 2'd0) else $error("output while halted");
endmodule
`default_nettype wire

### rtl/core/lrpc_queue.sv
// Result queue between parser and output: takes 0..2 items, gives 1.
// Uses lrpc_pkg.
`default_nettype none
module lrpc_queue
#(
    parameter int DEPTH_LOG2 = 2
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [1:0]    push_cnt,
    input  lrpc_pkg::result_t  push_a,
    input  lrpc_pkg::result_t  push_b,
    output logic               room2,
    output logic               out_valid,
    input  wire logic          out_ready,
    output lrpc_pkg::result_t  out_item
);
    localparam int DEPTH = 1 << DEPTH_LOG2;
    lrpc_pkg::result_t mem_reg [DEPTH];
    logic [DEPTH_LOG2-1:0] wp_reg, rp_reg;
    logic [DEPTH_LOG2:0]   cnt_reg, cnt_next;
    logic pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = cnt_reg != '0;
    assign out_item  = mem_reg[rp_reg];
    assign room2     = cnt_reg <= (DEPTH_LOG2+1)'(DEPTH - 2);
    assign cnt_next  = cnt_reg + {{(DEPTH_LOG2-1){1'b0}}, push_cnt} -
                       {{DEPTH_LOG2{1'b0}}, pop};

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0) mem_reg[wp_reg] <= push_a;
        if (push_cnt == 2'd2) mem_reg[wp_reg + 1'b1] <= push_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_reg + DEPTH_LOG2'(push_cnt);
            rp_reg  <= rp_reg + DEPTH_LOG2'(pop);
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt != 2'd0 |-> room2) else $error("queue overflow");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (DEPTH_LOG2+1)'(DEPTH)) else $error("count out of range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && push_cnt == 2'd0 |=> out_valid && $stable(cnt_reg))
        else $error("item lost");
endmodule
`default_nettype wire

### rtl/core/log_record_parse_check.sv
// Top level of the log record parser: config registers, parser front end,
// result queue. Uses lrpc_pkg, lrpc_front, lrpc_queue.
// Results are written into the queue registers and presented at the output from there.
// Throughput: one input byte per cycle while the queue has room; an item producing two
// results (last key/value byte plus status) drains as two separate output items.
// Input stalls only when the 4-entry queue lacks room for two results.
// Reset (rst_n, async low): parser restarts awaiting checksum, queue empty,
// registers at max_key_len=4096, max_value_len=1048576, put=0, delete=1.
`default_nettype none
module log_record_parse_check
#(
    parameter int QUEUE_LOG2 = 2
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] data_byte
    input  wire logic         s_tuser,   // [0] req_type
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [7:0] payload_byte, [10:8] status, [74:11] sequence_number,
    // [75] is_delete, [91:76] key_len, [115:92] value_len, [119:116] zero
    output logic [119:0]      m_tdata,
    output logic [1:0]        m_tuser,   // [1:0] kind
    output logic              m_tlast,   // end_of_run
    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    logic [15:0] max_key_reg;
    logic [23:0] max_val_reg;
    logic [7:0]  put_reg, del_reg;
    logic        room2;
    logic [1:0]  push_cnt;
    lrpc_pkg::result_t push_a, push_b, q_item;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_key_reg <= 16'd4096; max_val_reg <= 24'd1048576;
            put_reg <= 8'd0; del_reg <= 8'd1;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                lrpc_pkg::REG_MAX_KEY: max_key_reg <= pwdata[15:0];
                lrpc_pkg::REG_MAX_VAL: max_val_reg <= pwdata[23:0];
                lrpc_pkg::REG_PUT:     put_reg <= pwdata[7:0];
                lrpc_pkg::REG_DEL:     del_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            lrpc_pkg::REG_MAX_KEY: prdata = {16'd0, max_key_reg};
            lrpc_pkg::REG_MAX_VAL: prdata = {8'd0, max_val_reg};
            lrpc_pkg::REG_PUT:     prdata = {24'd0, put_reg};
            lrpc_pkg::REG_DEL:     prdata = {24'd0, del_reg};
            default:               prdata = '0;
        endcase
    end

    lrpc_front u_front
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .req_type(s_tuser), .data_byte(s_tdata),
        .max_key_len(max_key_reg), .max_value_len(max_val_reg),
        .put_code(put_reg), .delete_code(del_reg),
        .q_room2(room2), .push_cnt(push_cnt), .push_a(push_a), .push_b(push_b)
    );

    lrpc_queue #(.DEPTH_LOG2(QUEUE_LOG2)) u_queue
    (
        .clk(clk), .rst_n(rst_n),
        .push_cnt(push_cnt), .push_a(push_a), .push_b(push_b),
        .room2(room2), .out_valid(m_tvalid), .out_ready(m_tready), .out_item(q_item)
    );

    assign m_tuser = q_item.kind;
    assign m_tlast = q_item.end_of_run;
    assign m_tdata = {4'd0, q_item.value_len, q_item.key_len, q_item.is_delete,
                      q_item.sequence_number, q_item.status, q_item.payload_byte};
endmodule
`default_nettype wire
